[rtl/asmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmt_pkg: shared types and constants of the address source mask table
// Opcodes, fixed port widths and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package asmt_pkg;

	localparam int OP_W       = 2;
	localparam int KEY_HALF_W = 64;
	localparam int SRC_PORT_W = 8;
	localparam int OCC_W      = 10;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_run;
		logic do_clear;
		logic do_none;
		logic do_hit;
		logic do_miss;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            present;
		logic            match;
		logic            scan_done;
		logic            res_free;
	} status_t;

endpackage

[rtl/asmt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmt_ctrl: request sequencer
// Accepts one request, decodes it, runs the linear key search and issues the
// finishing command once the result register is free.
// ----------------------------------------------------------------------------
module asmt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  asmt_pkg::status_t sts,
	output asmt_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_HIT    = 5'b01000,
		ST_MISS   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.op == asmt_pkg::OP_CLEAR) begin
					if (sts.res_free) begin
						cmd.do_clear = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if ((sts.op inside {asmt_pkg::OP_ADD, asmt_pkg::OP_QUERY})
						&& sts.present) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else if (sts.res_free) begin
					cmd.do_none = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_SCAN: begin
				// hold the read pipeline on a match so the matched entry stays put
				if (sts.match) begin
					state_d = ST_HIT;
				end else if (sts.scan_done) begin
					state_d = ST_MISS;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			ST_HIT: begin
				if (sts.res_free) begin
					cmd.do_hit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MISS: begin
				if (sts.res_free) begin
					cmd.do_miss = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/asmt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmt_datapath: entry storage, search pipeline and result register
// Holds the key and mask memories, the entry count, the request registers
// and the output register.
// ----------------------------------------------------------------------------
module asmt_datapath #(
	parameter int CAPACITY    = 512,
	parameter int SOURCE_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  asmt_pkg::cmd_t                      cmd,
	output asmt_pkg::status_t                   sts,
	input  logic [asmt_pkg::OP_W-1:0]           opcode,
	input  logic                                key_present,
	input  logic [asmt_pkg::KEY_HALF_W-1:0]     key_high,
	input  logic [asmt_pkg::KEY_HALF_W-1:0]     key_low,
	input  logic [asmt_pkg::SRC_PORT_W-1:0]     source_mask,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic [asmt_pkg::SRC_PORT_W-1:0]     entry_sources,
	output logic                                multi_source,
	output logic                                dropped_full,
	output logic [asmt_pkg::OCC_W-1:0]          occupancy
);

	localparam int MASK_W = (SOURCE_BITS < asmt_pkg::SRC_PORT_W) ? SOURCE_BITS
		: asmt_pkg::SRC_PORT_W;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KEY_W  = 2 * asmt_pkg::KEY_HALF_W;

	// request registers
	logic [asmt_pkg::OP_W-1:0] req_op_q;
	logic                      req_present_q;
	logic [KEY_W-1:0]          req_key_q;
	logic [MASK_W-1:0]         req_mask_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q      <= opcode;
			req_present_q <= key_present;
			req_key_q     <= {key_high, key_low};
			req_mask_q    <= source_mask[MASK_W-1:0];
		end
	end

	// entry storage
	logic [KEY_W-1:0]  key_mem  [CAPACITY];
	logic [MASK_W-1:0] mask_mem [CAPACITY];

	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  issue_idx_q;
	logic              issue_more, rd_en;
	logic              rd_vld_s1;
	logic [KEY_W-1:0]  rd_key_s1;
	logic [MASK_W-1:0] rd_mask_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic              mem_we;
	logic [IDX_W-1:0]  wr_addr;
	logic [MASK_W-1:0] wr_mask;

	assign issue_more = (issue_idx_q < count_q);
	assign rd_en      = cmd.scan_run && issue_more;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[wr_addr]  <= req_key_q;
			mask_mem[wr_addr] <= wr_mask;
		end
		if (rd_en) begin
			rd_key_s1  <= key_mem[issue_idx_q[IDX_W-1:0]];
			rd_mask_s1 <= mask_mem[issue_idx_q[IDX_W-1:0]];
			rd_idx_s1  <= issue_idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else if (cmd.scan_start) begin
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				issue_idx_q <= issue_idx_q + 1'b1;
			end
		end
	end

	// result selection
	logic              adding, full, load;
	logic              res_hit_d, res_drop_d;
	logic [MASK_W-1:0] res_src_d;

	assign adding = (req_op_q == asmt_pkg::OP_ADD);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign load   = cmd.do_clear || cmd.do_none || cmd.do_hit || cmd.do_miss;

	always_comb begin
		res_hit_d  = 1'b0;
		res_drop_d = 1'b0;
		res_src_d  = '0;
		count_d    = count_q;
		mem_we     = 1'b0;
		wr_addr    = count_q[IDX_W-1:0];
		wr_mask    = req_mask_q;
		if (cmd.do_clear) begin
			count_d = '0;
		end else if (cmd.do_hit) begin
			res_hit_d = 1'b1;
			wr_addr   = rd_idx_s1;
			wr_mask   = rd_mask_s1 | req_mask_q;
			res_src_d = adding ? wr_mask : rd_mask_s1;
			mem_we    = adding;
		end else if (cmd.do_miss && adding) begin
			if (full) begin
				res_drop_d = 1'b1;
			end else begin
				mem_we    = 1'b1;
				res_src_d = req_mask_q;
				count_d   = count_q + 1'b1;
			end
		end
	end

	logic                             out_valid_q;
	logic                             hit_q, multi_q, drop_q;
	logic [asmt_pkg::SRC_PORT_W-1:0]  src_q;
	logic [asmt_pkg::OCC_W-1:0]       occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hit_q   <= res_hit_d;
			drop_q  <= res_drop_d;
			src_q   <= asmt_pkg::SRC_PORT_W'(res_src_d);
			multi_q <= ((res_src_d & (res_src_d - 1'b1)) != '0);
			occ_q   <= asmt_pkg::OCC_W'(count_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign entry_sources = src_q;
	assign multi_source  = multi_q;
	assign dropped_full  = drop_q;
	assign occupancy     = occ_q;

	assign sts.op        = req_op_q;
	assign sts.present   = req_present_q;
	assign sts.match     = rd_vld_s1 && (rd_key_s1 == req_key_q);
	assign sts.scan_done = !rd_vld_s1 && !issue_more;
	assign sts.res_free  = !out_valid_q || !out_stall;

endmodule

[rtl/address_source_mask_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_source_mask_table: associative table of 128-bit addresses
// Keeps up to CAPACITY entries of key and source mask. Clear empties the table,
// add merges a mask into a matching entry or appends one if not full, query
// reports presence, mask and whether several sources reported the key.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  request  | in_valid / in_stall   | opcode key_present key_high key_low
//           |                       | source_mask
//  result   | out_valid / out_stall | hit entry_sources multi_source
//           |                       | dropped_full occupancy
//
// Sequence: add and query with a key pass through capture, decode, the
// linear search over the N valid entries and a finishing step; the search
// reads one stored key per cycle from the key memory port through a
// registered read stage and stops at the first match. Clear, no-op opcodes
// and requests without a key finish from decode. One request is in work at a
// time; a new request is taken while an earlier result still waits.
// Reset: the entry count and all control state clear at once; the entry
// memories are not cleared, since only entries below the count are read.
// Stalls: a held result blocks only the finishing step of the next request.
// ----------------------------------------------------------------------------
module address_source_mask_table #(
	parameter int CAPACITY    = 512,
	parameter int SOURCE_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [asmt_pkg::OP_W-1:0]          opcode,
	input  logic                               key_present,
	input  logic [asmt_pkg::KEY_HALF_W-1:0]    key_high,
	input  logic [asmt_pkg::KEY_HALF_W-1:0]    key_low,
	input  logic [asmt_pkg::SRC_PORT_W-1:0]    source_mask,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [asmt_pkg::SRC_PORT_W-1:0]    entry_sources,
	output logic                               multi_source,
	output logic                               dropped_full,
	output logic [asmt_pkg::OCC_W-1:0]         occupancy
);

	// command and status between sequencer and datapath
	asmt_pkg::cmd_t    cmd;
	asmt_pkg::status_t sts;

	// sequencer: decode, search control, finish when the result slot is free
	asmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: request registers, memories, count and result register
	asmt_datapath #(
		.CAPACITY    (CAPACITY),
		.SOURCE_BITS (SOURCE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.key_present   (key_present),
		.key_high      (key_high),
		.key_low       (key_low),
		.source_mask   (source_mask),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.entry_sources (entry_sources),
		.multi_source  (multi_source),
		.dropped_full  (dropped_full),
		.occupancy     (occupancy)
	);

endmodule

[rtl/asmt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmt_checker: port-level checks of the address source mask table
// Watches both channels and flags result or sequencing slips.
// ----------------------------------------------------------------------------
module asmt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               hit,
	input logic [asmt_pkg::SRC_PORT_W-1:0]    entry_sources,
	input logic                               multi_source,
	input logic                               dropped_full,
	input logic [asmt_pkg::OCC_W-1:0]         occupancy
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(entry_sources)
			&& $stable(multi_source) && $stable(dropped_full) && $stable(occupancy))
		else $error("stalled result changed");

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in work");

	// a refused add reports no entry
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_full |-> !hit && (entry_sources == '0) && !multi_source)
		else $error("dropped add reports an entry");

	// multi-source flag follows the reported mask
	a_multi_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> multi_source == ((entry_sources & (entry_sources - 1'b1)) != '0))
		else $error("multi_source does not match entry_sources");

endmodule

bind address_source_mask_table asmt_checker u_asmt_checker (.*);
